// ----- sv/sobel_pkg.sv -----
// ----------------------------------------------------------------------------
// sobel_pkg: shared types and constants
// Control and status structs between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned PixW = 24;
  localparam logic [15:0] SatLimit = 16'd65280;
  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  typedef struct packed {
    logic load;      // latch input beat, start store read
    logic compute;   // window complete, run gradients
    logic sq_start;  // start root extraction
    logic sq_step;   // one root bit
    logic commit;    // write store, shift window, advance position
    logic clear;     // restart frame
  } sobel_cmd_t;

  typedef struct packed {
    logic sq_done;
  } sobel_sts_t;

endpackage

// ----- sv/sobel_edge_rgb.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_rgb: streaming 3x3 Sobel edge detector on RGB pixels
// Each pixel gives up to four results; border pixels come out black.
// ----------------------------------------------------------------------------
// Output stalls, and a previous result that still waits, hold a pixel up;
// the eight-step square root, run on all three channels together, takes
// most of a pixel's time. Results for pixel (r,c) are for (r-1,c-1),
// then the border pixels settled by it, the last one flagged by run_last.
// Writing a register restarts the frame at row 0, column 0. The line store
// needs no clearing after reset.
module sobel_edge_rgb import sobel_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_red,
  output logic [7:0]  edge_green,
  output logic [7:0]  edge_blue,
  output logic [15:0] out_row,
  output logic [10:0] out_col,
  output logic        run_last
);
  logic [11:0] frame_width;
  logic [15:0] frame_height;
  sobel_cmd_t  cmd;
  sobel_sts_t  sts;
  logic [16:0] row, height_eff;
  logic [11:0] col, width_eff;
  logic [23:0] edge_rgb, out_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 12'd640;
      frame_height <= 16'd480;
    end else if (cfg_we) begin
      if ({1'b0, cfg_index} == RegWidth) frame_width <= cfg_data[11:0];
      else frame_height <= cfg_data;
    end
  end

  sobel_dp #(.MaxWidth(MAX_WIDTH)) u_dp (
    .clk, .rst, .cmd, .sts, .pixel_red, .pixel_green, .pixel_blue,
    .frame_width, .frame_height, .row, .col, .width_eff, .height_eff, .edge_rgb);

  sobel_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .cfg_we, .cmd, .sts, .row, .col,
    .width_eff, .height_eff, .edge_rgb, .out_valid, .out_ready, .out_rgb,
    .out_row_o(out_row), .out_col_o(out_col), .out_last(run_last));

  assign edge_red = out_rgb[7:0];
  assign edge_green = out_rgb[15:8];
  assign edge_blue = out_rgb[23:16];
endmodule

// ----- sv/sobel_ram.sv -----
// ----------------------------------------------------------------------------
// sobel_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/sobel_dp.sv -----
// ----------------------------------------------------------------------------
// sobel_dp: Sobel datapath
// Line store, window, position counters, gradients and a bit-serial square
// root that steps all three channels together.
// ----------------------------------------------------------------------------
module sobel_dp import sobel_pkg::*; #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  sobel_cmd_t  cmd,
  output sobel_sts_t  sts,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  input  logic [11:0] frame_width,
  input  logic [15:0] frame_height,
  output logic [16:0] row,
  output logic [11:0] col,
  output logic [11:0] width_eff,
  output logic [16:0] height_eff,
  output logic [23:0] edge_rgb
);
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned AddrW = ColW + 1;

  logic [16:0] row_next;
  logic [11:0] col_next;
  logic [23:0] pix, top, mid;
  logic [23:0] win [6];
  logic [AddrW-1:0] addr_a, addr_b;
  logic [23:0] rd_a, rd_b;
  logic        rd_sel;
  logic [16:0] sq [3];
  logic [7:0]  root [3];
  logic [16:0] rem [3];
  logic [2:0]  bitn;
  logic        running;

  always_comb begin
    if (frame_width < 12'd3) width_eff = 12'd3;
    else if (32'(frame_width) > MaxWidth) width_eff = 12'(MaxWidth);
    else width_eff = frame_width;
    height_eff = (frame_height < 16'd3) ? 17'd3 : {1'b0, frame_height};
  end

  // wrap the position when the frame shape changed under it
  logic [16:0] r_use;
  logic [11:0] c_use;
  assign c_use = (col >= width_eff) ? 12'd0 : col;
  assign r_use = (row >= height_eff) ? 17'd0 : row;

  // two single-port halves: row parity picks which is top
  assign addr_a = AddrW'(c_use);
  assign addr_b = AddrW'(c_use);
  sobel_ram #(.Width(PixW), .Depth(2**AddrW / 2 * 2 / 2)) u_half0 (
    .clk, .we(cmd.commit & ~r_use[0]), .addr(addr_a[AddrW-2:0] ), .wdata(pix), .rdata(rd_a));
  sobel_ram #(.Width(PixW), .Depth(2**AddrW / 2 * 2 / 2)) u_half1 (
    .clk, .we(cmd.commit & r_use[0]), .addr(addr_b[AddrW-2:0]), .wdata(pix), .rdata(rd_b));

  assign rd_sel = r_use[0];
  assign top = rd_sel ? rd_b : rd_a;
  assign mid = rd_sel ? rd_a : rd_b;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix <= {pixel_blue, pixel_green, pixel_red};
    end
  end

  // gradients per channel, then squared sums
  always_ff @(posedge clk) begin
    logic signed [11:0] gx, gy;
    logic signed [21:0] gx_w, gy_w;
    logic [21:0] s;
    logic [7:0] tl, ml, bl, tm, bm, tr, mr, br;
    if (cmd.compute) begin
      for (int ch = 0; ch < 3; ch++) begin
        tl = win[0][ch*8 +: 8]; ml = win[1][ch*8 +: 8]; bl = win[2][ch*8 +: 8];
        tm = win[3][ch*8 +: 8]; bm = win[5][ch*8 +: 8];
        tr = top[ch*8 +: 8];    mr = mid[ch*8 +: 8];    br = pix[ch*8 +: 8];
        gx = ($signed({4'd0, tr}) + $signed({3'd0, mr, 1'b0}) + $signed({4'd0, br}))
           - ($signed({4'd0, tl}) + $signed({3'd0, ml, 1'b0}) + $signed({4'd0, bl}));
        gy = ($signed({4'd0, bl}) + $signed({3'd0, bm, 1'b0}) + $signed({4'd0, br}))
           - ($signed({4'd0, tl}) + $signed({3'd0, tm, 1'b0}) + $signed({4'd0, tr}));
        gx_w = 22'(gx);
        gy_w = 22'(gy);
        s = $unsigned(gx_w * gx_w) + $unsigned(gy_w * gy_w);
        sq[ch] <= (s > 22'(SatLimit)) ? 17'h1FFFF : s[16:0];
      end
    end
  end

  // restoring root, one bit a cycle for all three channels
  always_ff @(posedge clk) begin
    logic [7:0]  t;
    logic [16:0] tt;
    if (rst) begin
      running <= 1'b0;
      bitn <= 3'd7;
    end else if (cmd.sq_start) begin
      running <= 1'b1;
      bitn <= 3'd7;
      for (int ch = 0; ch < 3; ch++) root[ch] <= 8'd0;
    end else if (cmd.sq_step && running) begin
      for (int ch = 0; ch < 3; ch++) begin
        t = root[ch] | (8'd1 << bitn);
        tt = 17'(t) * 17'(t);
        if (tt <= sq[ch]) root[ch] <= t;
      end
      bitn <= bitn - 3'd1;
      if (bitn == 3'd0) running <= 1'b0;
    end
  end
  assign sts.sq_done = ~running;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rem[ch] = sq[ch] - 17'(root[ch]) * 17'(root[ch]);
      if (sq[ch] > 17'(SatLimit)) edge_rgb[ch*8 +: 8] = 8'd255;
      else if (rem[ch] > 17'(root[ch])) edge_rgb[ch*8 +: 8] = root[ch] + 8'd1;
      else edge_rgb[ch*8 +: 8] = root[ch];
    end
  end

  always_comb begin
    if (c_use >= width_eff - 12'd1) begin
      col_next = 12'd0;
      row_next = (r_use >= height_eff - 17'd1) ? 17'd0 : r_use + 17'd1;
    end else begin
      col_next = c_use + 12'd1;
      row_next = r_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row <= 17'd0;
      col <= 12'd0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (cmd.commit) begin
      row <= row_next;
      col <= col_next;
      win[0] <= win[3]; win[1] <= win[4]; win[2] <= win[5];
      win[3] <= top;    win[4] <= mid;    win[5] <= pix;
    end
  end
endmodule

// ----- sv/sobel_ctrl.sv -----
// ----------------------------------------------------------------------------
// sobel_ctrl: sequencer
// Walks one pixel through read, gradient, root and result emission.
// ----------------------------------------------------------------------------
module sobel_ctrl import sobel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cfg_we,
  output sobel_cmd_t  cmd,
  input  sobel_sts_t  sts,
  input  logic [16:0] row,
  input  logic [11:0] col,
  input  logic [11:0] width_eff,
  input  logic [16:0] height_eff,
  input  logic [23:0] edge_rgb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_rgb,
  output logic [15:0] out_row_o,
  output logic [10:0] out_col_o,
  output logic        out_last
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SGrad = 3'd2;
  localparam logic [2:0] SRoot = 3'd3;
  localparam logic [2:0] SEmit = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] pend, pend_next;  // results still to give, one bit per kind
  logic [16:0] r;
  logic [11:0] c;
  logic        lastc, lastr, hold;
  logic [3:0]  pick;

  assign c = (col >= width_eff) ? 12'd0 : col;
  assign r = (row >= height_eff) ? 17'd0 : row;
  assign lastc = (c == width_eff - 12'd1);
  assign lastr = (r == height_eff - 17'd1);
  assign in_ready = (state == SIdle) && !cfg_we;
  assign hold = out_valid && !out_ready;

  // lowest pending kind first
  always_comb begin
    pick = 4'd0;
    if (pend[0]) pick = 4'b0001;
    else if (pend[1]) pick = 4'b0010;
    else if (pend[2]) pick = 4'b0100;
    else if (pend[3]) pick = 4'b1000;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    pend_next = pend;
    cmd.clear = cfg_we;
    unique case (state)
      SIdle: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = SRead;
        end
      end
      SRead: state_next = SGrad;
      SGrad: begin
        cmd.compute = 1'b1;
        pend_next = {lastr && lastc, lastr && c != 12'd0,
                     lastc && r != 17'd0, r != 17'd0 && c != 12'd0};
        state_next = SRoot;
      end
      SRoot: begin
        state_next = SEmit;
        cmd.sq_start = 1'b1;
      end
      SEmit: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_done && !hold) begin
          if (pend == 4'd0) begin
            cmd.commit = 1'b1;
            state_next = SIdle;
          end else begin
            pend_next = pend & ~pick;
          end
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      pend <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend <= pend_next;
      if (state == SEmit && sts.sq_done && !hold && pend != 4'd0) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == SEmit && sts.sq_done && !hold && pend != 4'd0) begin
      out_last <= (pend & ~pick) == 4'd0;
      unique case (1'b1)
        pick[0]: begin
          out_rgb <= (r >= 17'd2 && c >= 12'd2) ? edge_rgb : 24'd0;
          out_row_o <= 16'(r - 17'd1);
          out_col_o <= 11'(c - 12'd1);
        end
        pick[1]: begin
          out_rgb <= 24'd0;
          out_row_o <= 16'(r - 17'd1);
          out_col_o <= 11'(width_eff - 12'd1);
        end
        pick[2]: begin
          out_rgb <= 24'd0;
          out_row_o <= 16'(height_eff - 17'd1);
          out_col_o <= 11'(c - 12'd1);
        end
        default: begin
          out_rgb <= 24'd0;
          out_row_o <= 16'(height_eff - 17'd1);
          out_col_o <= 11'(width_eff - 12'd1);
        end
      endcase
    end
  end
endmodule
